FILE: rtl/thick_line_quad_setup_assert.svh
// Assertion macros shared by the line setup RTL.
`ifndef THICK_LINE_QUAD_SETUP_ASSERT_SVH
`define THICK_LINE_QUAD_SETUP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TLQS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define TLQS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

FILE: rtl/tlqs_pkg.sv
package tlqs_pkg;

    localparam int MAG_W       = 16;              // normalized delta magnitude
    localparam int THICK_W     = 12;              // thickness, unsigned Q8.4
    localparam int SQ_W        = 2 * MAG_W;       // one squared magnitude
    localparam int RAD_SHIFT   = 16;              // radicand scale
    localparam int RAD_W       = 50;              // radicand, even width
    localparam int ROOT_W      = 25;              // rounded root
    localparam int UNIT_SHIFT  = 23;              // numerator scale of the unit vector
    localparam int NUM_W       = 40;              // divider numerator
    localparam int QUO_W       = 16;              // divider quotient
    localparam int UNIT_W      = 15;              // saturated unit magnitude
    localparam int UNIT_MAX    = 32767;
    localparam int PROD_W      = UNIT_W + THICK_W;
    localparam int OFF_SHIFT   = 16;
    localparam int OFF_MAG_W   = PROD_W - OFF_SHIFT;
    localparam int OFF_W       = OFF_MAG_W + 2;   // signed offset, Q.4

    typedef logic [MAG_W-1:0]  t_mag;
    typedef logic [ROOT_W-1:0] t_root;

endpackage

FILE: rtl/thick_line_quad_setup.sv
// Thick line quad setup: expands a segment (start, end, signed Q12.4) and a
// thickness (unsigned Q8.4) into the four corners of a quad, start+offset,
// end+offset, end-offset, start-offset, where the offset is half the thickness
// along the left perpendicular of the unit direction. A zero-length segment
// returns start for all four corners with the degenerate flag set in tuser.
// The block takes one segment per clock while the output buffer is not full
// and returns one quad per segment in order. The path runs through the
// 25-stage square root of the squared length with its rounding register and
// the 16-stage divider that forms the unit vector as a Q1.15 quotient. A
// two-entry output buffer lets the pipe keep taking input while one result
// waits on the master side.
`include "thick_line_quad_setup_assert.svh"

module thick_line_quad_setup #(
    parameter int COORD_WIDTH = 16,
    localparam int CW    = COORD_WIDTH,
    localparam int DW    = COORD_WIDTH + 1,
    localparam int IN_W  = ((4 * COORD_WIDTH + tlqs_pkg::THICK_W + 7) / 8) * 8,
    localparam int OUT_W = ((8 * (COORD_WIDTH + 1) + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // start_x, start_y, end_x, end_y, thickness, zero pad
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // corner_a_x, corner_a_y, corner_b_x, corner_b_y, corner_c_x, corner_c_y,
    // corner_d_x, corner_d_y, zero pad
    output logic [OUT_W-1:0] m_axis_tdata,
    // degenerate
    output logic             m_axis_tuser
);

    localparam int MW  = tlqs_pkg::MAG_W;
    localparam int TW  = tlqs_pkg::THICK_W;
    localparam int EW  = (CW > MW) ? CW : MW;
    localparam int SW  = $clog2(EW + 1);
    localparam int RW  = tlqs_pkg::RAD_W;
    localparam int NW  = tlqs_pkg::NUM_W;
    localparam int QW  = tlqs_pkg::QUO_W;
    localparam int UW  = tlqs_pkg::UNIT_W;
    localparam int PW  = tlqs_pkg::PROD_W;
    localparam int OW  = tlqs_pkg::OFF_W;
    localparam int OMW = tlqs_pkg::OFF_MAG_W;

    // Segment data that rides along the arithmetic.
    typedef struct packed {
        logic signed [CW-1:0] sx;
        logic signed [CW-1:0] sy;
        logic signed [CW-1:0] ex;
        logic signed [CW-1:0] ey;
        logic [TW-1:0]        th;
        logic                 nx;
        logic                 ny;
        logic                 deg;
    } t_geo;

    localparam int GEO_W = $bits(t_geo);
    localparam int STAG_W = GEO_W + 2 * MW;

    logic w_en;

    // Stage 0: capture the input transfer.
    logic r0_vld;
    t_geo r0_geo;

    // Stage 1: deltas, magnitudes, zero-length test.
    logic          r1_vld;
    t_geo          r1_geo;
    logic [EW-1:0] r1_mx;
    logic [EW-1:0] r1_my;

    // Stage 2: normalized magnitudes.
    logic           r2_vld;
    t_geo           r2_geo;
    tlqs_pkg::t_mag r2_mx;
    tlqs_pkg::t_mag r2_my;

    // Stage 3: squares.
    logic                        r3_vld;
    t_geo                        r3_geo;
    tlqs_pkg::t_mag              r3_mx;
    tlqs_pkg::t_mag              r3_my;
    logic [tlqs_pkg::SQ_W-1:0]   r3_sqx;
    logic [tlqs_pkg::SQ_W-1:0]   r3_sqy;

    // Stage 4: radicand.
    logic              r4_vld;
    logic [STAG_W-1:0] r4_tag;
    logic [RW-1:0]     r4_rad;

    // Root unit output.
    logic              w_sq_vld;
    tlqs_pkg::t_root   w_root;
    logic [STAG_W-1:0] w_sq_tag;
    t_geo              w_sq_geo;
    tlqs_pkg::t_mag    w_sq_mx;
    tlqs_pkg::t_mag    w_sq_my;

    // Stage 5: divider operands.
    logic                  r5_vld;
    t_geo                  r5_geo;
    logic [1:0][NW-1:0]    r5_num;
    tlqs_pkg::t_root       r5_den;

    // Divider output.
    logic                  w_dv_vld;
    logic [1:0][QW-1:0]    w_quo;
    logic [GEO_W-1:0]      w_dv_tag;
    t_geo                  w_dv_geo;
    logic [UW-1:0]         w_ux;
    logic [UW-1:0]         w_uy;

    // Stage 6: thickness products.
    logic          r6_vld;
    t_geo          r6_geo;
    logic [PW-1:0] r6_px;
    logic [PW-1:0] r6_py;

    // Stage 7: rounded offsets.
    logic                 r7_vld;
    t_geo                 r7_geo;
    logic signed [OW-1:0] r7_ox;
    logic signed [OW-1:0] r7_oy;
    logic [PW:0]          w_rx;
    logic [PW:0]          w_ry;
    logic [OMW-1:0]       w_qx;
    logic [OMW-1:0]       w_qy;

    // Stage 8: corners.
    logic                 r8_vld;
    logic                 r8_deg;
    logic [8*DW-1:0]      r8_corn;

    logic                 w_out_vld;
    logic [8*DW:0]        w_out;
    logic [7:0][DW-1:0]   w_cor;
    logic                 w_deg_ok;
    logic                 w_sides_ok;

    logic [EW-1:0]        w_any;
    logic [SW-1:0]        w_shift;
    logic signed [DW-1:0] w_dx;
    logic signed [DW-1:0] w_dy;

    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r0_vld <= s_axis_tvalid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= w_sq_vld;
            r6_vld <= w_dv_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    // Delta of the segment vector; its magnitude is taken in stage 1.
    assign w_dx = DW'(r0_geo.ex) - DW'(r0_geo.sx);
    assign w_dy = DW'(r0_geo.ey) - DW'(r0_geo.sy);

    // Find the right shift that brings the larger magnitude below 2^16.
    assign w_any = r1_mx | r1_my;
    always_comb begin
        w_shift = '0;
        for (int i = MW; i < EW; i++) begin
            if (w_any[i]) begin
                w_shift = SW'(i - MW + 1);
            end
        end
    end

    assign w_sq_geo = w_sq_tag[STAG_W-1 -: GEO_W];
    assign w_sq_mx  = w_sq_tag[2*MW-1:MW];
    assign w_sq_my  = w_sq_tag[MW-1:0];
    assign w_dv_geo = w_dv_tag;

    // Saturate the unit vector magnitudes to unsigned Q0.15.
    assign w_ux = (w_quo[0] > QW'(tlqs_pkg::UNIT_MAX)) ? UW'(tlqs_pkg::UNIT_MAX)
                                                       : UW'(w_quo[0]);
    assign w_uy = (w_quo[1] > QW'(tlqs_pkg::UNIT_MAX)) ? UW'(tlqs_pkg::UNIT_MAX)
                                                       : UW'(w_quo[1]);

    // Round half away from zero on the magnitude.
    assign w_rx = (PW + 1)'(r6_px) + ((PW + 1)'(1) << (tlqs_pkg::OFF_SHIFT - 1));
    assign w_ry = (PW + 1)'(r6_py) + ((PW + 1)'(1) << (tlqs_pkg::OFF_SHIFT - 1));
    assign w_qx = OMW'(w_rx >> tlqs_pkg::OFF_SHIFT);
    assign w_qy = OMW'(w_ry >> tlqs_pkg::OFF_SHIFT);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 0
            r0_geo <= {s_axis_tdata[0*CW +: CW], s_axis_tdata[1*CW +: CW],
                       s_axis_tdata[2*CW +: CW], s_axis_tdata[3*CW +: CW],
                       s_axis_tdata[4*CW +: TW], 1'b0, 1'b0, 1'b0};

            // stage 1
            r1_geo <= {r0_geo.sx, r0_geo.sy, r0_geo.ex, r0_geo.ey, r0_geo.th,
                       w_dx[DW-1], w_dy[DW-1], (w_dx == '0) && (w_dy == '0)};
            r1_mx  <= EW'(CW'(w_dx[DW-1] ? -w_dx : w_dx));
            r1_my  <= EW'(CW'(w_dy[DW-1] ? -w_dy : w_dy));

            // stage 2
            r2_geo <= r1_geo;
            r2_mx  <= MW'(r1_mx >> w_shift);
            r2_my  <= MW'(r1_my >> w_shift);

            // stage 3
            r3_geo <= r2_geo;
            r3_mx  <= r2_mx;
            r3_my  <= r2_my;
            r3_sqx <= tlqs_pkg::SQ_W'(r2_mx) * tlqs_pkg::SQ_W'(r2_mx);
            r3_sqy <= tlqs_pkg::SQ_W'(r2_my) * tlqs_pkg::SQ_W'(r2_my);

            // stage 4
            r4_tag <= {r3_geo, r3_mx, r3_my};
            r4_rad <= ((RW)'(r3_sqx) + RW'(r3_sqy)) << tlqs_pkg::RAD_SHIFT;

            // stage 5
            r5_geo    <= w_sq_geo;
            r5_num[0] <= (NW'(w_sq_mx) << tlqs_pkg::UNIT_SHIFT) + NW'(w_root >> 1);
            r5_num[1] <= (NW'(w_sq_my) << tlqs_pkg::UNIT_SHIFT) + NW'(w_root >> 1);
            r5_den    <= w_root;

            // stage 6
            r6_geo <= w_dv_geo;
            r6_px  <= PW'(w_ux) * PW'(w_dv_geo.th);
            r6_py  <= PW'(w_uy) * PW'(w_dv_geo.th);

            // stage 7: offset x follows -u.y, offset y follows u.x
            r7_geo <= r6_geo;
            if (r6_geo.deg) begin
                r7_ox <= '0;
                r7_oy <= '0;
            end else begin
                r7_ox <= r6_geo.ny ? OW'(w_qy) : -OW'(w_qy);
                r7_oy <= r6_geo.nx ? -OW'(w_qx) : OW'(w_qx);
            end

            // stage 8
            r8_deg  <= r7_geo.deg;
            r8_corn <= {DW'(r7_geo.sy) - DW'(r7_oy), DW'(r7_geo.sx) - DW'(r7_ox),
                        DW'(r7_geo.ey) - DW'(r7_oy), DW'(r7_geo.ex) - DW'(r7_ox),
                        DW'(r7_geo.ey) + DW'(r7_oy), DW'(r7_geo.ex) + DW'(r7_ox),
                        DW'(r7_geo.sy) + DW'(r7_oy), DW'(r7_geo.sx) + DW'(r7_ox)};
        end
    end

    tlqs_sqrt #(
        .TAG_W (STAG_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r4_vld),
        .i_rad   (r4_rad),
        .i_tag   (r4_tag),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_tag   (w_sq_tag)
    );

    tlqs_div #(
        .LANES (2),
        .TAG_W (GEO_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r5_vld),
        .i_num   (r5_num),
        .i_den   (r5_den),
        .i_tag   (r5_geo),
        .o_vld   (w_dv_vld),
        .o_quo   (w_quo),
        .o_tag   (w_dv_tag)
    );

    // Hold the pipe whenever the output buffer is full.
    tlqs_skid #(
        .W (8 * DW + 1)
    ) u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r8_vld),
        .i_data  ({r8_deg, r8_corn}),
        .o_rdy   (w_en),
        .o_vld   (w_out_vld),
        .o_data  (w_out),
        .i_rdy   (m_axis_tready)
    );

    assign m_axis_tvalid = w_out_vld;
    assign m_axis_tuser  = w_out[8*DW];
    assign m_axis_tdata  = OUT_W'(w_out[8*DW-1:0]);

    // Corner fields in tdata order: a.x, a.y, b.x, b.y, c.x, c.y, d.x, d.y.
    assign w_cor      = w_out[8*DW-1:0];
    assign w_deg_ok   = !(w_out_vld && w_out[8*DW])
                        || ((w_cor[0] == w_cor[6]) && (w_cor[1] == w_cor[7]));
    assign w_sides_ok = !w_out_vld
                        || (DW'(w_cor[0] - w_cor[2]) == DW'(w_cor[6] - w_cor[4]));

    `TLQS_ASSERT(a_deg_corners, i_clk, i_rst_n, w_deg_ok, "degenerate corners differ")
    `TLQS_ASSERT(a_quad_sides, i_clk, i_rst_n, w_sides_ok, "quad sides not parallel in x")
    `TLQS_ASSERT(a_rdy_idle, i_clk, i_rst_n, w_out_vld || w_en, "stall with empty output")

endmodule

FILE: rtl/tlqs_sqrt.sv
module tlqs_sqrt #(
    parameter int TAG_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [tlqs_pkg::RAD_W-1:0]  i_rad,
    input  logic [TAG_W-1:0]            i_tag,
    output logic                        o_vld,
    output tlqs_pkg::t_root             o_root,
    output logic [TAG_W-1:0]            o_tag
);

    localparam int RW = tlqs_pkg::RAD_W;
    localparam int NI = RW / 2;

    logic          r_vld [NI];
    logic [RW-1:0] r_n   [NI];
    logic [RW-1:0] r_r   [NI];
    logic [TAG_W-1:0] r_tag [NI];

    logic             r_out_vld;
    tlqs_pkg::t_root  r_root;
    logic [TAG_W-1:0] r_out_tag;

    // One bit of the root per stage, from one bit pair of the radicand, highest first.
    for (genvar k = 0; k < NI; k++) begin : g_stage
        logic          v_in;
        logic [RW-1:0] n_in;
        logic [RW-1:0] r_in;
        logic [TAG_W-1:0] tag_in;
        logic [RW-1:0] bitv;
        logic [RW-1:0] sum;
        logic [RW-1:0] n_n;
        logic [RW-1:0] n_r;

        if (k == 0) begin : g_first
            assign v_in   = i_vld;
            assign n_in   = i_rad;
            assign r_in   = '0;
            assign tag_in = i_tag;
        end else begin : g_next
            assign v_in   = r_vld[k-1];
            assign n_in   = r_n[k-1];
            assign r_in   = r_r[k-1];
            assign tag_in = r_tag[k-1];
        end

        assign bitv = RW'(1) << (2 * (NI - 1 - k));
        assign sum  = r_in + bitv;

        always_comb begin
            if (n_in >= sum) begin
                n_n = n_in - sum;
                n_r = (r_in >> 1) + bitv;
            end else begin
                n_n = n_in;
                n_r = r_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= n_n;
                r_r[k]   <= n_r;
                r_tag[k] <= tag_in;
            end
        end
    end

    // Round to nearest: bump the root when the remainder exceeds it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[NI-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root    <= (r_n[NI-1] > r_r[NI-1]) ? tlqs_pkg::ROOT_W'(r_r[NI-1] + RW'(1))
                                                 : tlqs_pkg::ROOT_W'(r_r[NI-1]);
            r_out_tag <= r_tag[NI-1];
        end
    end

    assign o_vld  = r_out_vld;
    assign o_root = r_root;
    assign o_tag  = r_out_tag;

endmodule

FILE: rtl/tlqs_div.sv
module tlqs_div #(
    parameter int LANES = 2,
    parameter int TAG_W = 1
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_en,
    input  logic                                    i_vld,
    input  logic [LANES-1:0][tlqs_pkg::NUM_W-1:0]   i_num,
    input  tlqs_pkg::t_root                         i_den,
    input  logic [TAG_W-1:0]                        i_tag,
    output logic                                    o_vld,
    output logic [LANES-1:0][tlqs_pkg::QUO_W-1:0]   o_quo,
    output logic [TAG_W-1:0]                        o_tag
);

    localparam int NW = tlqs_pkg::NUM_W;
    localparam int QW = tlqs_pkg::QUO_W;
    localparam int DW = tlqs_pkg::ROOT_W;

    logic                          r_vld [QW];
    logic [LANES-1:0][NW-1:0]      r_rem [QW];
    logic [LANES-1:0][QW-1:0]      r_quo [QW];
    logic [DW-1:0]                 r_den [QW];
    logic [TAG_W-1:0]              r_tag [QW];

    // Restoring division, one quotient bit per stage, highest first.
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                     v_in;
        logic [LANES-1:0][NW-1:0] rem_in;
        logic [LANES-1:0][QW-1:0] quo_in;
        logic [DW-1:0]            den_in;
        logic [TAG_W-1:0]         tag_in;
        logic [NW:0]              dsh;
        logic [LANES-1:0][NW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;

        if (k == 0) begin : g_first
            assign v_in   = i_vld;
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
            assign tag_in = i_tag;
        end else begin : g_next
            assign v_in   = r_vld[k-1];
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
            assign tag_in = r_tag[k-1];
        end

        assign dsh = (NW + 1)'(den_in) << (QW - 1 - k);

        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            for (int l = 0; l < LANES; l++) begin
                if ({1'b0, rem_in[l]} >= dsh) begin
                    n_rem[l]         = NW'({1'b0, rem_in[l]} - dsh);
                    n_quo[l][QW-1-k] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_quo[k] <= n_quo;
                r_den[k] <= den_in;
                r_tag[k] <= tag_in;
            end
        end
    end

    assign o_vld = r_vld[QW-1];
    assign o_quo = r_quo[QW-1];
    assign o_tag = r_tag[QW-1];

endmodule

FILE: rtl/tlqs_skid.sv
`include "thick_line_quad_setup_assert.svh"

module tlqs_skid #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_vld,
    input  logic [W-1:0] i_data,
    output logic         o_rdy,
    output logic         o_vld,
    output logic [W-1:0] o_data,
    input  logic         i_rdy
);

    logic         r_out_vld;
    logic [W-1:0] r_out;
    logic         r_skid_vld;
    logic [W-1:0] r_skid;

    assign o_rdy  = !r_skid_vld;
    assign o_vld  = r_out_vld;
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_skid_vld) begin
            if (!r_out_vld || i_rdy) begin
                r_out_vld <= i_vld;
            end else if (i_vld) begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_rdy) begin
            r_out_vld  <= 1'b1;
            r_skid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            if (!r_out_vld || i_rdy) begin
                r_out <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end else if (i_rdy) begin
            r_out <= r_skid;
        end
    end

    `TLQS_ASSERT(a_skid_behind_out, i_clk, i_rst_n, r_skid_vld |-> r_out_vld, "orphan skid")
    `TLQS_ASSERT_NEXT(a_skid_holds, i_clk, i_rst_n, r_skid_vld && !i_rdy, r_skid_vld, "skid lost")
    `TLQS_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, r_out_vld && !i_rdy, r_out_vld, "output lost")

endmodule
